// ----- sv/wmsdc_pkg.sv -----
package wmsdc_pkg;

  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_ITEM_W   = 38;
  localparam int unsigned OUT_ITEM_W  = 52;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [SPEED_W-1:0] CRAWL_RESET = 16'd20;
  localparam logic [SPEED_W-1:0] LOWER_RESET = 16'd5;
  localparam logic [SPEED_W-1:0] UPPER_RESET = 16'd5;
  localparam logic [SPEED_W-1:0] TURN_DROP   = 16'd2;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    MV_STOP  = 3'd0,
    MV_FWD   = 3'd1,
    MV_LEFT  = 3'd2,
    MV_BACK  = 3'd3,
    MV_RIGHT = 3'd4
  } move_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRAWL = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_UPPER = 2'd2
  } cfg_idx_t;

  // last field in the lowest bits
  typedef struct packed {
    logic               correct_right;
    logic               correct_left;
    logic [COUNT_W-1:0] wheel_count;
    logic [2:0]         movement;
    logic               system_go;
  } in_item_t;

  typedef struct packed {
    logic               reverse_led;
    logic               forward_led;
    logic [COUNT_W-1:0] distance_tracked;
    logic [SPEED_W-1:0] drive_speed;
    dir_t               drive_direction;
  } out_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] correction_lower;
    logic [SPEED_W-1:0] correction_upper;
  } cfg_t;

endpackage

// ----- sv/wheel_motor_speed_direction_ctrl_unit.sv -----
// an accepted item is held in the input register, then its result in the result register on out_*
// throughput: one item per cycle while out_tready is high; the only loop is the update of the
//   tracker, count, direction and speed registers from their own values
// reset: synchronous on rst_n low; clears both stage valids, the move state and
//   loads the configuration registers with their default values
module wheel_motor_speed_direction_ctrl_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // system_go, movement[2:0], wheel_count[31:0], correct_left, correct_right, zero pad
  input  logic [wmsdc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_direction[1:0], drive_speed[15:0], distance_tracked[31:0], forward_led,
  // reverse_led, zero pad
  output logic [wmsdc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [wmsdc_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [wmsdc_pkg::SPEED_W-1:0]       cfg_wdata
);

  wmsdc_pkg::cfg_t      cfg_r;
  wmsdc_pkg::in_item_t  in_item_r;
  logic                 in_valid_r;
  wmsdc_pkg::out_item_t out_item_r;
  logic                 out_valid_r;
  wmsdc_pkg::out_item_t result;
  logic                 advance;

  // the held item moves on when the result register is empty or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  // the input register refills in the same cycle it hands its item on
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(wmsdc_pkg::OUT_TDATA_W - wmsdc_pkg::OUT_ITEM_W){1'b0}}, out_item_r};

  // configuration registers, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed       <= wmsdc_pkg::CRAWL_RESET;
      cfg_r.correction_lower <= wmsdc_pkg::LOWER_RESET;
      cfg_r.correction_upper <= wmsdc_pkg::UPPER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        wmsdc_pkg::CFG_CRAWL: cfg_r.base_speed       <= cfg_wdata;
        wmsdc_pkg::CFG_LOWER: cfg_r.correction_lower <= cfg_wdata;
        wmsdc_pkg::CFG_UPPER: cfg_r.correction_upper <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= wmsdc_pkg::in_item_t'(in_tdata[wmsdc_pkg::IN_ITEM_W-1:0]);
    end
  end

  // move state and per-item result logic
  wmsdc_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

endmodule

// ----- sv/wmsdc_fwd_speed.sv -----
module wmsdc_fwd_speed (
  input  logic [wmsdc_pkg::SPEED_W-1:0] speed_cur,
  input  wmsdc_pkg::cfg_t               cfg,
  input  logic                          correct_left,
  input  logic                          correct_right,
  output logic [wmsdc_pkg::SPEED_W-1:0] speed_fwd
);

  logic [16:0]        seed;
  logic [16:0]        nudged;
  logic [16:0]        hi;
  logic signed [17:0] lo;
  logic signed [17:0] s;

  always_comb begin
    // seed at crawl when stopped
    seed = (speed_cur == '0) ? {1'b0, cfg.base_speed} : {1'b0, speed_cur};

    nudged = seed;
    if (correct_right && !correct_left && seed != 17'h0FFFF) begin
      nudged = seed + 17'd1;
    end else if (correct_left && !correct_right && seed != 17'd0) begin
      nudged = seed - 17'd1;
    end

    // band limits at full width, lower may go negative
    lo = signed'({2'b00, cfg.base_speed}) - signed'({2'b00, cfg.correction_lower});
    hi = {1'b0, cfg.base_speed} + {1'b0, cfg.correction_upper};

    s = signed'({1'b0, nudged});
    if (s < lo) begin
      s = lo;
    end
    if (s > signed'({1'b0, hi})) begin
      s = signed'({1'b0, hi});
    end
    speed_fwd = s[15:0];
  end

endmodule

// ----- sv/wmsdc_state.sv -----
module wmsdc_state (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  wmsdc_pkg::in_item_t  item,
  input  wmsdc_pkg::cfg_t      cfg,
  output wmsdc_pkg::out_item_t result
);

  logic [wmsdc_pkg::COUNT_W-1:0] last_count_r, last_count_nxt;
  logic [wmsdc_pkg::COUNT_W-1:0] tracker_r, tracker_nxt;
  wmsdc_pkg::dir_t               dir_r, dir_nxt;
  logic [wmsdc_pkg::SPEED_W-1:0] speed_r, speed_nxt;

  logic [wmsdc_pkg::COUNT_W-1:0] diff;
  logic [wmsdc_pkg::SPEED_W-1:0] speed_fwd;
  logic [wmsdc_pkg::SPEED_W-1:0] speed_turn;

  wmsdc_fwd_speed u_fwd_speed (
    .speed_cur     (speed_r),
    .cfg           (cfg),
    .correct_left  (item.correct_left),
    .correct_right (item.correct_right),
    .speed_fwd     (speed_fwd)
  );

  always_comb begin
    diff       = item.wheel_count - last_count_r;
    speed_turn = (cfg.base_speed >= wmsdc_pkg::TURN_DROP) ?
                 cfg.base_speed - wmsdc_pkg::TURN_DROP : '0;

    last_count_nxt = item.wheel_count;
    tracker_nxt    = tracker_r;
    dir_nxt        = dir_r;
    speed_nxt      = speed_r;

    if (item.system_go) begin
      case (item.movement)
        wmsdc_pkg::MV_FWD: begin
          tracker_nxt = tracker_r + diff;
          dir_nxt     = wmsdc_pkg::DIR_FWD;
          speed_nxt   = speed_fwd;
        end
        wmsdc_pkg::MV_LEFT: begin
          tracker_nxt = tracker_r + diff;
          dir_nxt     = wmsdc_pkg::DIR_FWD;
          speed_nxt   = speed_turn;
        end
        wmsdc_pkg::MV_BACK, wmsdc_pkg::MV_RIGHT: begin
          tracker_nxt = tracker_r - diff;
          dir_nxt     = wmsdc_pkg::DIR_REV;
          speed_nxt   = speed_turn;
        end
        default: begin
          // stop and unknown codes: clear the move, keep direction
          last_count_nxt = '0;
          tracker_nxt    = '0;
          speed_nxt      = '0;
        end
      endcase
    end else begin
      last_count_nxt = '0;
      tracker_nxt    = '0;
      dir_nxt        = wmsdc_pkg::DIR_OFF;
      speed_nxt      = '0;
    end

    result.drive_direction  = dir_nxt;
    result.drive_speed      = speed_nxt;
    result.distance_tracked = tracker_nxt;
    result.forward_led      = (dir_nxt == wmsdc_pkg::DIR_FWD) && (speed_nxt != '0);
    result.reverse_led      = ((dir_nxt == wmsdc_pkg::DIR_REV) && (speed_nxt != '0)) ||
                              item.correct_right;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      tracker_r    <= '0;
      dir_r        <= wmsdc_pkg::DIR_OFF;
      speed_r      <= '0;
    end else if (step) begin
      last_count_r <= last_count_nxt;
      tracker_r    <= tracker_nxt;
      dir_r        <= dir_nxt;
      speed_r      <= speed_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import wmsdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // clock, reset and block ports
  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_tvalid    = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata     = '0;
  logic                   out_tvalid;
  logic                   out_tready   = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en    = 1'b0;
  cfg_idx_t               cfg_addr     = CFG_CRAWL;
  logic [SPEED_W-1:0]     cfg_wdata    = '0;

  // items still to send and results still owed by the block
  in_item_t  ticks_to_send[$];
  out_item_t owed_results[$];

  // own copy of the configuration
  logic [SPEED_W-1:0] crawl_cfg;
  logic [SPEED_W-1:0] lower_cfg;
  logic [SPEED_W-1:0] upper_cfg;

  // own copy of the move state
  logic [COUNT_W-1:0] prev_count;
  logic [COUNT_W-1:0] dist_acc;
  dir_t               dir_now;
  logic [SPEED_W-1:0] speed_now;

  // stimulus bookkeeping
  logic [COUNT_W-1:0] enc_count = '0;
  bit                 no_idle   = 1'b0;
  int                 send_gap;
  int                 stall_left;
  int unsigned        mismatch_count = 0;
  int unsigned        results_seen   = 0;
  int unsigned        cycle_count    = 0;

  wheel_motor_speed_direction_ctrl_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // speed for a forward tick: seed at crawl, nudge by one, clamp to the band
  function automatic logic [SPEED_W-1:0] forward_speed(logic cl, logic cr);
    int lo_lim;
    int hi_lim;
    int s;
    lo_lim = int'(crawl_cfg) - int'(lower_cfg);
    hi_lim = int'(crawl_cfg) + int'(upper_cfg);
    s = (speed_now == '0) ? int'(crawl_cfg) : int'(speed_now);
    if (!cl && cr) begin
      if (s < 65535) s = s + 1;
    end else if (cl && !cr) begin
      if (s > 0) s = s - 1;
    end
    // lower limit may be negative, then it never bites
    if (s < lo_lim) s = lo_lim;
    if (s > hi_lim) s = hi_lim;
    return s[SPEED_W-1:0];
  endfunction

  // advance the move state by one control tick and give the drive outputs
  function automatic out_item_t drive_step(in_item_t it);
    out_item_t          r;
    logic [COUNT_W-1:0] delta;
    logic [SPEED_W-1:0] turn_speed;
    turn_speed = (crawl_cfg >= TURN_DROP) ? crawl_cfg - TURN_DROP : '0;
    if (it.system_go) begin
      delta = it.wheel_count - prev_count;
      case (move_t'(it.movement))
        MV_FWD, MV_LEFT:  dist_acc = dist_acc + delta;
        MV_BACK, MV_RIGHT: dist_acc = dist_acc - delta;
        default: ;
      endcase
      prev_count = it.wheel_count;
      case (move_t'(it.movement))
        MV_FWD: begin
          dir_now   = DIR_FWD;
          speed_now = forward_speed(it.correct_left, it.correct_right);
        end
        MV_LEFT: begin
          dir_now   = DIR_FWD;
          speed_now = turn_speed;
        end
        MV_BACK, MV_RIGHT: begin
          dir_now   = DIR_REV;
          speed_now = turn_speed;
        end
        default: begin
          // stop and unknown codes: clear the move, keep the direction
          speed_now  = '0;
          dist_acc   = '0;
          prev_count = '0;
        end
      endcase
    end else begin
      dir_now    = DIR_OFF;
      speed_now  = '0;
      dist_acc   = '0;
      prev_count = '0;
    end
    r.drive_direction  = dir_now;
    r.drive_speed      = speed_now;
    r.distance_tracked = dist_acc;
    r.forward_led      = (dir_now == DIR_FWD) && (speed_now != '0);
    // right correction lights the reverse led in every mode
    r.reverse_led      = ((dir_now == DIR_REV) && (speed_now != '0)) || it.correct_right;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= 200)
      $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h",
               $time, results_seen, field, got, want);
  endtask

  task automatic add_tick(logic go, logic [2:0] mv, logic [COUNT_W-1:0] cnt,
                          logic cl, logic cr);
    in_item_t it;
    it.system_go     = go;
    it.movement      = mv;
    it.wheel_count   = cnt;
    it.correct_left  = cl;
    it.correct_right = cr;
    ticks_to_send.push_back(it);
  endtask

  // encoder moves mostly a little, sometimes far or anywhere
  function automatic logic [COUNT_W-1:0] next_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) enc_count = enc_count + $urandom_range(0, 50);
    else if (k < 65) enc_count = enc_count - $urandom_range(0, 50);
    else if (k < 80) enc_count = enc_count + $urandom;
    else if (k < 92) enc_count = enc_count;
    else enc_count = $urandom;
    return enc_count;
  endfunction

  // runs of one movement with random counts and correction flags
  task automatic queue_random_runs(int n);
    int         left;
    int         len;
    int         k;
    logic       go;
    logic [2:0] mv;
    left = n;
    while (left > 0) begin
      k  = $urandom_range(0, 99);
      go = ($urandom_range(0, 99) >= 6);
      if (k < 40) mv = MV_FWD;
      else if (k < 52) mv = MV_LEFT;
      else if (k < 64) mv = MV_BACK;
      else if (k < 76) mv = MV_RIGHT;
      else if (k < 88) mv = MV_STOP;
      else mv = 3'($urandom_range(5, 7));
      len = $urandom_range(1, 12);
      while (len > 0 && left > 0) begin
        add_tick(go, mv, next_count(), 1'($urandom), 1'($urandom));
        len--;
        left--;
      end
    end
  endtask

  // block until every item is sent and every result is in
  task automatic wait_drained();
    do @(negedge clk);
    while (ticks_to_send.size() != 0 || in_tvalid || owed_results.size() != 0);
  endtask

  task automatic set_config(logic [SPEED_W-1:0] crawl, logic [SPEED_W-1:0] lower,
                            logic [SPEED_W-1:0] upper);
    wait_drained();
    repeat (3) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_CRAWL;
    cfg_wdata <= crawl;
    @(posedge clk);
    cfg_addr  <= CFG_LOWER;
    cfg_wdata <= lower;
    @(posedge clk);
    cfg_addr  <= CFG_UPPER;
    cfg_wdata <= upper;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // item driver, fed from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        in_tdata  <= {{(IN_TDATA_W-IN_ITEM_W){1'b0}}, ticks_to_send.pop_front()};
        in_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // configuration shadow, updated on each register write
  always @(posedge clk) begin
    if (!rst_n) begin
      crawl_cfg = CRAWL_RESET;
      lower_cfg = LOWER_RESET;
      upper_cfg = UPPER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_CRAWL: crawl_cfg = cfg_wdata;
        CFG_LOWER: lower_cfg = cfg_wdata;
        CFG_UPPER: upper_cfg = cfg_wdata;
        default: ;
      endcase
    end
  end

  // monitor: check results against the oldest owed one, then predict new items
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      prev_count = '0;
      dist_acc   = '0;
      dir_now    = DIR_OFF;
      speed_now  = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_item_t'(out_tdata[OUT_ITEM_W-1:0]);
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = owed_results.pop_front();
          if (got.drive_direction !== want.drive_direction)
            report_mismatch("drive_direction", got.drive_direction, want.drive_direction);
          if (got.drive_speed !== want.drive_speed)
            report_mismatch("drive_speed", got.drive_speed, want.drive_speed);
          if (got.distance_tracked !== want.distance_tracked)
            report_mismatch("distance_tracked", got.distance_tracked,
                            want.distance_tracked);
          if (got.forward_led !== want.forward_led)
            report_mismatch("forward_led", got.forward_led, want.forward_led);
          if (got.reverse_led !== want.reverse_led)
            report_mismatch("reverse_led", got.reverse_led, want.reverse_led);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(drive_step(in_item_t'(in_tdata[IN_ITEM_W-1:0])));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed ticks on the reset configuration (band 15 to 25)
    add_tick(1'b0, MV_STOP, 32'h0000_0000, 1'b0, 1'b0);
    add_tick(1'b0, MV_FWD, 32'hFFFF_FFFF, 1'b0, 1'b1);   // right led with go low
    add_tick(1'b1, MV_FWD, 32'h0000_000A, 1'b0, 1'b0);   // seed at crawl
    add_tick(1'b1, MV_FWD, 32'h0000_0019, 1'b0, 1'b1);
    for (p = 0; p < 6; p++)
      add_tick(1'b1, MV_FWD, 32'h0000_0020 + p, 1'b0, 1'b1); // climbs into upper clamp
    add_tick(1'b1, MV_FWD, 32'h0000_0030, 1'b1, 1'b1);   // both flags, no nudge
    add_tick(1'b1, MV_FWD, 32'h0000_0031, 1'b1, 1'b0);   // nudge down
    add_tick(1'b1, MV_LEFT, 32'h7FFF_FFFF, 1'b1, 1'b0);
    add_tick(1'b1, MV_BACK, 32'h8000_0000, 1'b0, 1'b0);
    add_tick(1'b1, MV_RIGHT, 32'h0000_0000, 1'b1, 1'b1);
    add_tick(1'b1, MV_STOP, 32'h1234_5678, 1'b0, 1'b1);  // stop keeps direction
    add_tick(1'b1, 3'd5, 32'hFFFF_FFFF, 1'b1, 1'b0);     // unknown codes act as stop
    add_tick(1'b1, 3'd6, 32'h5555_5555, 1'b0, 1'b1);
    add_tick(1'b1, 3'd7, 32'hAAAA_AAAA, 1'b1, 1'b1);
    add_tick(1'b1, MV_FWD, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_tick(1'b0, MV_BACK, 32'h1234_5678, 1'b1, 1'b0);

    // narrowest band, no idling at all
    no_idle = 1'b1;
    set_config(16'd2, 16'd0, 16'd0);
    queue_random_runs(60);
    no_idle = 1'b0;

    // widest: upper limit never applies, lower limit at zero
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random_runs(60);

    // lower margin above crawl: no lower limit, nudging down to zero
    set_config(16'd3, 16'd200, 16'd3);
    queue_random_runs(60);

    // upper limit right at the top of the range
    set_config(16'hFFFE, 16'd3, 16'd1);
    queue_random_runs(30);
    wait_drained();                 // sender holds off until the block is empty
    queue_random_runs(30);

    // crawl below two: turn speed saturates at zero
    set_config(16'd1, 16'd0, 16'd2);
    queue_random_runs(40);

    for (p = 0; p < 5; p++) begin
      no_idle = (p == 2);
      if ($urandom_range(0, 1))
        set_config(16'($urandom_range(2, 40)), 16'($urandom_range(0, 20)),
                   16'($urandom_range(0, 20)));
      else
        set_config(16'($urandom_range(2, 65535)), 16'($urandom), 16'($urandom));
      queue_random_runs(70);
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
